// ===== hw/rtl/apmc_pkg.sv =====
// ============================================================================
// apmc_pkg
// Shared types, constants and helper functions of the aperture memory
// controller with DMA.
// ============================================================================
package apmc_pkg;

    // Register file geometry. The file is kept as little-endian 32-bit words.
    localparam int REG_FILE_BYTES = 64;
    localparam int REG_WORDS      = REG_FILE_BYTES / 4;
    localparam int WORD_IDX_W     = $clog2(REG_WORDS);
    localparam int OFF_W          = $clog2(REG_FILE_BYTES);

    // DMA words per tick: the tick budget is clamped to the smaller of these.
    localparam int MAX_WORDS_PER_TICK = 32;
    localparam int RESULT_CAP         = 32;
    localparam int BUDGET_CAP         = (MAX_WORDS_PER_TICK < RESULT_CAP) ?
                                        MAX_WORDS_PER_TICK : RESULT_CAP;

    // Command queue between the front and the back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Address map.
    localparam logic [31:0] REG_BASE = 32'h0400_0000;
    localparam logic [31:0] REG_LAST = 32'h0400_003F;

    // Window codes (top address byte) and the aperture byte holding the bank.
    localparam logic [7:0] WIN_02 = 8'h02;
    localparam logic [7:0] WIN_03 = 8'h03;
    localparam logic [7:0] WIN_16 = 8'h16;
    localparam logic [7:0] WIN_17 = 8'h17;
    localparam logic [7:0] WIN_18 = 8'h18;
    localparam logic [OFF_W-1:0] BANK_OFF_02 = OFF_W'(8'h1A);
    localparam logic [OFF_W-1:0] BANK_OFF_03 = OFF_W'(8'h1B);
    localparam logic [OFF_W-1:0] BANK_OFF_16 = OFF_W'(8'h12);
    localparam logic [OFF_W-1:0] BANK_OFF_17 = OFF_W'(8'h13);
    localparam logic [OFF_W-1:0] BANK_OFF_18 = OFF_W'(8'h1C);
    localparam logic [6:0]       BANK_SEL_BITS = 7'h7F;

    // Status half-word and DMA register words.
    localparam logic [OFF_W-1:0]      STATUS_OFF  = OFF_W'(8'h04);
    localparam logic [31:0]           STATUS_KEEP = 32'h0000_F000;
    localparam logic [31:0]           STATUS_W1C  = 32'h0000_0FC0 | 32'h0000_003F;
    localparam logic [15:0]           STATUS_DONE = 16'h1000;
    localparam logic [WORD_IDX_W-1:0] W_ID        = WORD_IDX_W'(8'h00 >> 2);
    localparam logic [WORD_IDX_W-1:0] W_STATUS    = WORD_IDX_W'(8'h04 >> 2);
    localparam logic [WORD_IDX_W-1:0] W_SRC       = WORD_IDX_W'(8'h30 >> 2);
    localparam logic [WORD_IDX_W-1:0] W_DST       = WORD_IDX_W'(8'h34 >> 2);
    localparam logic [WORD_IDX_W-1:0] W_CTL       = WORD_IDX_W'(8'h38 >> 2);
    localparam logic [31:0]           DMA_STEP    = 32'd4;
    localparam logic [2:0]            DMA_SIZE    = 3'd4;

    // Access sizes.
    localparam logic [2:0] SIZE_1 = 3'd1;
    localparam logic [2:0] SIZE_2 = 3'd2;
    localparam logic [2:0] SIZE_4 = 3'd4;

    typedef enum logic [1:0] {
        KIND_RD   = 2'd0,
        KIND_WR   = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RK_REG    = 3'd0,
        RK_BUS_RD = 3'd1,
        RK_BUS_WR = 3'd2,
        RK_COPY   = 3'd3,
        RK_ERR    = 3'd4,
        RK_DONE   = 3'd5
    } t_rkind;

    typedef enum logic [2:0] {
        OP_REG_RD,
        OP_REG_WR,
        OP_BUS_RD,
        OP_BUS_WR,
        OP_ERR,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [31:0]      address;
        logic [2:0]       size;
        logic [31:0]      wdata;     // already masked to the access size
        logic [5:0]       budget;    // already clamped
        logic [OFF_W-1:0] bank_off;  // aperture byte that holds the bank
    } t_cmd;

    typedef struct packed {
        t_rkind      result_kind;
        logic [31:0] bus_address;
        logic [30:0] copy_destination;
        logic [31:0] data;
        logic [2:0]  access_size;
        logic        dma_irq;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_ERR,
        BS_RD1,
        BS_REG,
        BS_WR1,
        BS_BANK,
        BS_TK_CTL,
        BS_TK_SRC,
        BS_TK_DST,
        BS_TK_STAT,
        BS_COPY,
        BS_DONE_ONLY,
        BS_WB_SRC,
        BS_WB_DST,
        BS_WB_CTL,
        BS_WB_STAT
    } t_bstate;

    function automatic logic [31:0] size_mask(input logic [2:0] size);
        logic [31:0] m;
        unique case (size)
            SIZE_1:  m = 32'h0000_00FF;
            SIZE_2:  m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Contents of a word that has not been written since reset.
    function automatic logic [31:0] reset_word(input logic [WORD_IDX_W-1:0] idx,
                                               input logic is_master);
        logic [31:0] w;
        w = ((idx == W_ID) && !is_master) ? 32'hFFFF_FFFF : 32'h0000_0000;
        return w;
    endfunction

endpackage

// ===== hw/rtl/apmc_if.sv =====
// ============================================================================
// apmc_req_if / apmc_res_if
// Valid/ready channels for request words and result words.
// ============================================================================
interface apmc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [2:0]  size_bytes;
    logic [31:0] write_data;
    logic [5:0]  cycle_budget;

    modport source (output valid, kind, address, size_bytes, write_data, cycle_budget,
                    input ready);
    modport sink   (input valid, kind, address, size_bytes, write_data, cycle_budget,
                    output ready);
endinterface

interface apmc_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [31:0] bus_address;
    logic [30:0] copy_destination;
    logic [31:0] data;
    logic [2:0]  access_size;
    logic        dma_irq;
    logic        last;

    modport source (output valid, result_kind, bus_address, copy_destination, data,
                    access_size, dma_irq, last,
                    input ready);
    modport sink   (input valid, result_kind, bus_address, copy_destination, data,
                    access_size, dma_irq, last,
                    output ready);
endinterface

// ===== hw/rtl/aperture_memctl_with_dma.sv =====
// ============================================================================
// aperture_memctl_with_dma
// Memory controller with a 64-byte register file, window address translation
// and a word-copy DMA engine driven by time ticks.
//
// Channel   Direction  Handshake            Word contents
// i_req     in         valid/ready          kind, address, size_bytes,
//                                           write_data, cycle_budget
// o_res     out        valid/ready          result_kind, bus_address,
//                                           copy_destination, data,
//                                           access_size, dma_irq, last
// i_cfg_*   in         write enable only    is_master role bit
//
// A register read fetches the two words around the offset, and a register
// write writes both back; a window access reads the bank word. A DMA tick
// reads the control, source, destination and status words, sends one word
// per copy (or one done-only word), then writes back source, destination,
// control and, on completion, status; a tick that finds the engine off, or
// has no budget while words remain, ends after the control read.
// The front accepts a word whenever the 2-entry command queue has room, so
// requests keep flowing while a result waits on o_res.
// Reset (i_rst_n low at a clock edge) empties the queue and the output
// register and returns the file to zero, with the id word set by the role.
// ============================================================================
module aperture_memctl_with_dma import apmc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    apmc_req_if.sink   i_req,
    apmc_res_if.source o_res
);

    // Commands leave the front already classified: the back never looks at
    // the raw kind, and the size check, register range check and window
    // lookup are all settled before a command is queued.
    logic q_push;
    t_cmd q_cmd;
    logic q_full;
    logic q_pop;
    t_cmd q_head;
    logic q_empty;

    apmc_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd)
    );

    // The queue lets the front keep taking requests while the back is busy
    // with a DMA burst or stalled on a full output register.
    apmc_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // The back owns the register file and the role bit. A configuration
    // write only changes the role and reloads the id word; the user must issue
    // it only while the block is idle, which the block itself does not enforce.
    apmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_res       (o_res)
    );

endmodule

// ===== hw/rtl/apmc_front.sv =====
// ============================================================================
// apmc_front
// Accepts request words and classifies them into back-end commands.
// ============================================================================
module apmc_front import apmc_pkg::*; (
    apmc_req_if.sink i_req,
    input  logic     i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    logic        size_ok;
    logic        in_regs;
    logic [6:0]  budget_ext;
    t_kind       kind;

    assign kind = t_kind'(i_req.kind);

    always_comb begin
        size_ok    = (i_req.size_bytes == SIZE_1) || (i_req.size_bytes == SIZE_2) ||
                     (i_req.size_bytes == SIZE_4);
        in_regs    = (i_req.address >= REG_BASE) && (i_req.address <= REG_LAST);
        budget_ext = {1'b0, i_req.cycle_budget};

        o_q_cmd          = '0;
        o_q_cmd.address  = i_req.address;
        o_q_cmd.size     = i_req.size_bytes;
        o_q_cmd.wdata    = i_req.write_data & size_mask(i_req.size_bytes);
        o_q_cmd.budget   = (budget_ext > 7'(BUDGET_CAP)) ? 6'(BUDGET_CAP)
                                                         : i_req.cycle_budget;
        o_q_cmd.op       = OP_ERR;
        o_q_cmd.bank_off = BANK_OFF_02;

        unique case (i_req.address[31:24])
            WIN_02:  o_q_cmd.bank_off = BANK_OFF_02;
            WIN_03:  o_q_cmd.bank_off = BANK_OFF_03;
            WIN_16:  o_q_cmd.bank_off = BANK_OFF_16;
            WIN_17:  o_q_cmd.bank_off = BANK_OFF_17;
            WIN_18:  o_q_cmd.bank_off = BANK_OFF_18;
            default: o_q_cmd.bank_off = BANK_OFF_02;
        endcase

        // Ticks are taken first, then the size is checked, then the register file, then the windows.
        priority if (kind == KIND_TICK) begin
            o_q_cmd.op = OP_TICK;
        end else if (!size_ok) begin
            o_q_cmd.op = OP_ERR;
        end else if (in_regs) begin
            o_q_cmd.op = (kind == KIND_WR) ? OP_REG_WR : OP_REG_RD;
        end else if ((i_req.address[31:24] == WIN_02) || (i_req.address[31:24] == WIN_03) ||
                     (i_req.address[31:24] == WIN_16) || (i_req.address[31:24] == WIN_17) ||
                     (i_req.address[31:24] == WIN_18)) begin
            o_q_cmd.op = (kind == KIND_WR) ? OP_BUS_WR : OP_BUS_RD;
        end else begin
            o_q_cmd.op = OP_ERR;
        end
    end

    // Unknown kinds are taken and dropped without a command.
    assign i_req.ready = !i_q_full;
    assign o_q_push    = i_req.valid && !i_q_full && (kind != KIND_NONE);

endmodule

// ===== hw/rtl/apmc_cmdq.sv =====
// ============================================================================
// apmc_cmdq
// Short command queue between the front and the back.
// ============================================================================
module apmc_cmdq import apmc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  push_ok;
    logic                  pop_ok;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CMDQ_CNT_W'(push_ok) - CMDQ_CNT_W'(pop_ok);
        end
    end

endmodule

// ===== hw/rtl/apmc_back.sv =====
// ============================================================================
// apmc_back
// Carries out commands against the register file: register accesses, window
// translation and the DMA engine, and holds the result output register.
// ============================================================================
module apmc_back import apmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_q_empty,
    input  t_cmd        i_q_head,
    output logic        o_q_pop,
    apmc_res_if.source  o_res
);

    // Register file: single write port, single registered read port.
    logic [31:0]           r_mem [REG_WORDS];
    logic [REG_WORDS-1:0]  r_vld;
    logic [31:0]           r_rd_word;
    logic                  r_is_master;

    t_bstate     r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [31:0] r_w0, n_w0;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [7:0]  r_ctl, n_ctl;
    logic [23:0] r_len, n_len;
    logic [5:0]  r_count, n_count;
    logic        r_done, n_done;
    t_res        r_res, n_res;
    logic        r_res_vld, n_res_vld;

    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_idx;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_idx;
    logic [31:0]           wr_data;
    logic                  out_free;

    // Datapath helpers.
    logic [63:0]           pair;
    logic [4:0]            shamt;
    logic [31:0]           mask;
    logic [31:0]           old_val;
    logic [31:0]           new_val;
    logic [63:0]           new_pair;
    logic [WORD_IDX_W-1:0] w0_idx;
    logic [31:0]           bank_word;
    logic [6:0]            bank;
    logic [23:0]           tick_len;
    logic [5:0]            tick_cnt;
    logic [23:0]           tick_left;

    assign out_free = !r_res_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_word <= r_vld[rd_idx] ? r_mem[rd_idx] : reset_word(rd_idx, r_is_master);
        end
    end

    // A role change makes the id word read back as the new role's value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_is_master <= 1'b1;
        end else begin
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_is_master <= i_cfg_wdata;
                r_vld[W_ID] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_w0    <= n_w0;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_ctl   <= n_ctl;
        r_len   <= n_len;
        r_count <= n_count;
        r_done  <= n_done;
        r_res   <= n_res;
    end

    always_comb begin
        // Register access merge: the two words around the offset as one pair.
        pair     = {r_rd_word, r_w0};
        shamt    = {r_cmd.address[1:0], 3'b000};
        mask     = size_mask(r_cmd.size);
        old_val  = 32'(pair >> shamt) & mask;
        new_val  = r_cmd.wdata;
        if (r_cmd.address[OFF_W-1:0] == STATUS_OFF) begin
            new_val = ((old_val & STATUS_KEEP) | (old_val & ~r_cmd.wdata & STATUS_W1C)) & mask;
        end
        new_pair = (pair & ~({32'h0, mask} << shamt)) | ({32'h0, new_val} << shamt);
        w0_idx   = r_cmd.address[OFF_W-1:2];

        bank_word = r_rd_word >> {r_cmd.bank_off[1:0], 3'b000};
        bank      = bank_word[6:0] & BANK_SEL_BITS;

        tick_len  = r_rd_word[23:0];
        tick_cnt  = (tick_len < {18'h0, r_cmd.budget}) ? tick_len[5:0] : r_cmd.budget;
        tick_left = tick_len - {18'h0, tick_cnt};
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_w0      = r_w0;
        n_src     = r_src;
        n_dst     = r_dst;
        n_ctl     = r_ctl;
        n_len     = r_len;
        n_count   = r_count;
        n_done    = r_done;
        n_res     = r_res;
        n_res_vld = r_res_vld && !o_res.ready;
        o_q_pop   = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = i_q_head.address[OFF_W-1:2];
        wr_en     = 1'b0;
        wr_idx    = W_SRC;
        wr_data   = r_src;

        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    unique case (i_q_head.op)
                        OP_REG_RD, OP_REG_WR: begin
                            rd_en   = 1'b1;
                            rd_idx  = i_q_head.address[OFF_W-1:2];
                            n_state = BS_RD1;
                        end
                        OP_BUS_RD, OP_BUS_WR: begin
                            rd_en   = 1'b1;
                            rd_idx  = i_q_head.bank_off[OFF_W-1:2];
                            n_state = BS_BANK;
                        end
                        OP_TICK: begin
                            rd_en   = 1'b1;
                            rd_idx  = W_CTL;
                            n_state = BS_TK_CTL;
                        end
                        default: begin
                            n_state = BS_ERR;
                        end
                    endcase
                end
            end

            BS_ERR: begin
                if (out_free) begin
                    n_res_vld     = 1'b1;
                    n_res         = '0;
                    n_res.result_kind = RK_ERR;
                    n_res.bus_address = r_cmd.address;
                    n_res.access_size = r_cmd.size;
                    n_res.last        = 1'b1;
                    n_state       = BS_IDLE;
                end
            end

            BS_RD1: begin
                n_w0    = r_rd_word;
                rd_en   = 1'b1;
                rd_idx  = w0_idx + 1'b1;
                n_state = BS_REG;
            end

            BS_REG: begin
                if (out_free) begin
                    n_res_vld         = 1'b1;
                    n_res             = '0;
                    n_res.result_kind = RK_REG;
                    n_res.access_size = r_cmd.size;
                    n_res.last        = 1'b1;
                    if (r_cmd.op == OP_REG_WR) begin
                        n_res.data = new_val;
                        wr_en      = 1'b1;
                        wr_idx     = w0_idx;
                        wr_data    = new_pair[31:0];
                        n_w0       = new_pair[63:32];
                        n_state    = BS_WR1;
                    end else begin
                        n_res.data = old_val;
                        n_state    = BS_IDLE;
                    end
                end
            end

            BS_WR1: begin
                // The upper word is rewritten unchanged when the access fits in one.
                wr_en   = 1'b1;
                wr_idx  = w0_idx + 1'b1;
                wr_data = r_w0;
                n_state = BS_IDLE;
            end

            BS_BANK: begin
                if (out_free) begin
                    n_res_vld         = 1'b1;
                    n_res             = '0;
                    n_res.access_size = r_cmd.size;
                    n_res.last        = 1'b1;
                    if (bank == '0) begin
                        n_res.result_kind = RK_ERR;
                        n_res.bus_address = r_cmd.address;
                    end else begin
                        n_res.bus_address = {1'b0, bank, r_cmd.address[23:0]};
                        if (r_cmd.op == OP_BUS_WR) begin
                            n_res.result_kind = RK_BUS_WR;
                            n_res.data        = r_cmd.wdata;
                        end else begin
                            n_res.result_kind = RK_BUS_RD;
                        end
                    end
                    n_state = BS_IDLE;
                end
            end

            BS_TK_CTL: begin
                n_ctl   = r_rd_word[31:24];
                n_len   = tick_left;
                n_count = tick_cnt;
                n_done  = (tick_left == '0);
                if (!r_rd_word[24] || ((tick_cnt == '0) && (tick_left != '0))) begin
                    n_state = BS_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = W_SRC;
                    n_state = BS_TK_SRC;
                end
            end

            BS_TK_SRC: begin
                n_src   = r_rd_word;
                rd_en   = 1'b1;
                rd_idx  = W_DST;
                n_state = BS_TK_DST;
            end

            BS_TK_DST: begin
                n_dst   = r_rd_word;
                rd_en   = 1'b1;
                rd_idx  = W_STATUS;
                n_state = BS_TK_STAT;
            end

            BS_TK_STAT: begin
                n_w0    = r_rd_word;
                n_state = (r_count != '0) ? BS_COPY : BS_DONE_ONLY;
            end

            BS_COPY: begin
                if (out_free) begin
                    n_res_vld              = 1'b1;
                    n_res                  = '0;
                    n_res.result_kind      = RK_COPY;
                    n_res.bus_address      = {1'b0, r_src[30:0]};
                    n_res.copy_destination = r_dst[30:0];
                    n_res.access_size      = DMA_SIZE;
                    n_res.last             = (r_count == 6'd1);
                    n_res.dma_irq          = (r_count == 6'd1) && r_done;
                    n_src                  = r_src + DMA_STEP;
                    n_dst                  = r_dst + DMA_STEP;
                    n_count                = r_count - 1'b1;
                    if (r_count == 6'd1) begin
                        n_state = BS_WB_SRC;
                    end
                end
            end

            BS_DONE_ONLY: begin
                if (out_free) begin
                    n_res_vld         = 1'b1;
                    n_res             = '0;
                    n_res.result_kind = RK_DONE;
                    n_res.access_size = DMA_SIZE;
                    n_res.dma_irq     = 1'b1;
                    n_res.last        = 1'b1;
                    n_state           = BS_WB_SRC;
                end
            end

            BS_WB_SRC: begin
                wr_en   = 1'b1;
                wr_idx  = W_SRC;
                wr_data = r_src;
                n_state = BS_WB_DST;
            end

            BS_WB_DST: begin
                wr_en   = 1'b1;
                wr_idx  = W_DST;
                wr_data = r_dst;
                n_state = BS_WB_CTL;
            end

            BS_WB_CTL: begin
                wr_en   = 1'b1;
                wr_idx  = W_CTL;
                wr_data = {(r_done ? 8'h00 : r_ctl), r_len};
                n_state = r_done ? BS_WB_STAT : BS_IDLE;
            end

            BS_WB_STAT: begin
                wr_en   = 1'b1;
                wr_idx  = W_STATUS;
                wr_data = {r_w0[31:16], STATUS_DONE};
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_res.valid            = r_res_vld;
    assign o_res.result_kind      = r_res.result_kind;
    assign o_res.bus_address      = r_res.bus_address;
    assign o_res.copy_destination = r_res.copy_destination;
    assign o_res.data             = r_res.data;
    assign o_res.access_size      = r_res.access_size;
    assign o_res.dma_irq          = r_res.dma_irq;
    assign o_res.last             = r_res.last;

endmodule

// ===== hw/rtl/apmc_checker.sv =====
// ============================================================================
// apmc_checker
// Port-level checks on the result channel of the memory controller.
// ============================================================================
module apmc_checker import apmc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [2:0]  i_res_kind,
    input logic [31:0] i_res_bus_address,
    input logic [30:0] i_res_copy_destination,
    input logic [31:0] i_res_data,
    input logic [2:0]  i_res_access_size,
    input logic        i_res_dma_irq,
    input logic        i_res_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_kind) && $stable(i_res_bus_address) &&
             $stable(i_res_data) && $stable(i_res_last)))
        else $error("result word changed while stalled");

    a_irq_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_dma_irq) |-> i_res_last)
        else $error("dma interrupt on a word that is not the last");

    a_copy_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind == RK_COPY)) |->
            ((i_res_access_size == DMA_SIZE) && !i_res_bus_address[31] &&
             (i_res_data == '0)))
        else $error("malformed copy word");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind != RK_COPY)) |-> i_res_last)
        else $error("single-word result without last");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && ((i_res_kind == RK_REG) || (i_res_kind == RK_DONE))) |->
            ((i_res_bus_address == '0) && (i_res_copy_destination == '0)))
        else $error("register or done word carries an address");

endmodule

bind aperture_memctl_with_dma apmc_checker u_apmc_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_res_valid            (o_res.valid),
    .i_res_ready            (o_res.ready),
    .i_res_kind             (o_res.result_kind),
    .i_res_bus_address      (o_res.bus_address),
    .i_res_copy_destination (o_res.copy_destination),
    .i_res_data             (o_res.data),
    .i_res_access_size      (o_res.access_size),
    .i_res_dma_irq          (o_res.dma_irq),
    .i_res_last             (o_res.last)
);

// ===== dv/testbench.sv =====
// ============================================================================
// Testbench for aperture_memctl_with_dma
// Drives CPU reads, CPU writes and DMA ticks into the controller and checks
// every result word against an in-bench model of the register file, the
// window translation and the DMA engine. Directed tests come first, then a
// long random run with role changes between phases and random stalls.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import apmc_pkg::*;

    // Register offsets and field values used by the model and the tests.
    localparam logic [5:0]  OFF_ID       = 6'h00;
    localparam logic [5:0]  OFF_STATUS   = 6'h04;
    localparam logic [5:0]  OFF_BANK_16  = 6'h12;
    localparam logic [5:0]  OFF_BANK_17  = 6'h13;
    localparam logic [5:0]  OFF_BANK_02  = 6'h1A;
    localparam logic [5:0]  OFF_BANK_03  = 6'h1B;
    localparam logic [5:0]  OFF_BANK_18  = 6'h1C;
    localparam logic [5:0]  OFF_SRC      = 6'h30;
    localparam logic [5:0]  OFF_DST      = 6'h34;
    localparam logic [5:0]  OFF_CTL      = 6'h38;
    localparam logic [5:0]  OFF_CTL_BYTE = 6'h3B;
    localparam logic [31:0] STATUS_HOLD  = 32'h0000_F000;
    localparam logic [31:0] STATUS_CLR   = 32'h0000_0FFF;
    localparam logic [31:0] STATUS_FIN   = 32'h0000_1000;
    localparam int          WORDS_MAX    = 32;
    localparam int          RANDOM_ITEMS = 420;
    localparam int          CALM_TAIL    = 80;
    localparam int          DRAIN_CYCLES = 50;

    typedef struct {
        t_kind       kind;
        logic [31:0] address;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic [5:0]  budget;
    } t_req_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    apmc_req_if req_bus ();
    apmc_res_if res_bus ();

    aperture_memctl_with_dma dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the controller: the 64-byte register file and the role bit.
    logic [7:0] file_bytes [64];
    logic       master_role;

    // Result words the controller still owes us, oldest first.
    t_res awaited_results [$];

    int  fault_count  = 0;
    int  items_sent   = 0;
    bit  no_idle      = 1'b0;

    // ------------------------------------------------------------------------
    // Model of the register file, the windows and the DMA engine.
    // ------------------------------------------------------------------------

    function automatic logic [31:0] file_read(input logic [5:0] off, input int n);
        logic [31:0] v;
        logic [5:0]  idx;
        v = '0;
        for (int i = 0; i < n; i++) begin
            idx = off + 6'(i);      // byte indices wrap inside the file
            v |= 32'(file_bytes[idx]) << (8 * i);
        end
        return v;
    endfunction

    function automatic void file_write(input logic [5:0] off, input int n,
                                       input logic [31:0] v);
        logic [5:0] idx;
        for (int i = 0; i < n; i++) begin
            idx = off + 6'(i);
            file_bytes[idx] = v[8*i +: 8];
        end
    endfunction

    // The id word follows the role: zero for the master, all ones otherwise.
    function automatic void load_id_word();
        file_write(OFF_ID, 4, master_role ? 32'h0000_0000 : 32'hFFFF_FFFF);
    endfunction

    function automatic void file_reset();
        foreach (file_bytes[i]) file_bytes[i] = 8'h00;
        master_role = 1'b1;
        load_id_word();
    endfunction

    function automatic void push_result(input t_rkind k, input logic [31:0] addr,
                                        input logic [30:0] dst, input logic [31:0] data,
                                        input logic [2:0] size, input logic irq,
                                        input logic fin);
        t_res r;
        r.result_kind      = k;
        r.bus_address      = addr;
        r.copy_destination = dst;
        r.data             = data;
        r.access_size      = size;
        r.dma_irq          = irq;
        r.last             = fin;
        awaited_results.push_back(r);
    endfunction

    // Bank for a window access; zero when the window is not mapped.
    function automatic logic [6:0] window_bank(input logic [31:0] addr);
        logic [7:0] b;
        case (addr[31:24])
            WIN_02:  b = file_bytes[OFF_BANK_02];
            WIN_03:  b = file_bytes[OFF_BANK_03];
            WIN_16:  b = file_bytes[OFF_BANK_16];
            WIN_17:  b = file_bytes[OFF_BANK_17];
            WIN_18:  b = file_bytes[OFF_BANK_18];
            default: b = 8'h00;
        endcase
        return b[6:0];
    endfunction

    function automatic void model_cpu_access(input bit is_write, input t_req_word w);
        logic [31:0] mask;
        logic [31:0] v;
        logic [31:0] old;
        logic [6:0]  bank;
        logic [5:0]  off;
        int          n;
        if (w.size != SIZE_1 && w.size != SIZE_2 && w.size != SIZE_4) begin
            push_result(RK_ERR, w.address, '0, '0, w.size, 1'b0, 1'b1);
            return;
        end
        n    = int'(w.size);
        mask = (n == 4) ? 32'hFFFF_FFFF : ((32'h1 << (8 * n)) - 32'h1);
        if (w.address >= REG_BASE && w.address <= REG_LAST) begin
            off = w.address[5:0];
            if (!is_write) begin
                v = file_read(off, n);
            end else begin
                v = w.wdata & mask;
                // The status half-word keeps its top nibble and clears
                // the low 12 bits where ones are written.
                if (off == OFF_STATUS) begin
                    old = file_read(off, n);
                    v = ((old & STATUS_HOLD) | (old & ~v & STATUS_CLR)) & mask;
                end
                file_write(off, n, v);
            end
            push_result(RK_REG, '0, '0, v, w.size, 1'b0, 1'b1);
            return;
        end
        bank = window_bank(w.address);
        if (bank == 7'd0) begin
            push_result(RK_ERR, w.address, '0, '0, w.size, 1'b0, 1'b1);
        end else if (is_write) begin
            push_result(RK_BUS_WR, {1'b0, bank, w.address[23:0]}, '0, w.wdata & mask,
                        w.size, 1'b0, 1'b1);
        end else begin
            push_result(RK_BUS_RD, {1'b0, bank, w.address[23:0]}, '0, '0,
                        w.size, 1'b0, 1'b1);
        end
    endfunction

    function automatic void model_dma_tick(input logic [5:0] budget);
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] ctl_word;
        logic [23:0] len;
        logic [7:0]  ctl;
        int          cap;
        int          count;
        bit          done;
        src      = file_read(OFF_SRC, 4);
        dst      = file_read(OFF_DST, 4);
        ctl_word = file_read(OFF_CTL, 4);
        len      = ctl_word[23:0];
        ctl      = ctl_word[31:24];
        if (!ctl[0]) return;
        cap   = (int'(budget) > WORDS_MAX) ? WORDS_MAX : int'(budget);
        count = (int'(len) < cap) ? int'(len) : cap;
        len   = len - 24'(count);
        done  = (len == 24'd0);
        for (int i = 0; i < count; i++) begin
            push_result(RK_COPY, src & 32'h7FFF_FFFF, dst[30:0], '0, DMA_SIZE,
                        (i + 1 == count) && done, i + 1 == count);
            src += DMA_STEP;
            dst += DMA_STEP;
        end
        if (done) begin
            // Completion clears the whole control byte and flags the status.
            ctl = 8'h00;
            file_write(OFF_STATUS, 2, STATUS_FIN);
            if (count == 0)
                push_result(RK_DONE, '0, '0, '0, DMA_SIZE, 1'b1, 1'b1);
        end
        file_write(OFF_SRC, 4, src);
        file_write(OFF_DST, 4, dst);
        file_write(OFF_CTL, 4, {ctl, len});
    endfunction

    function automatic void controller_step(input t_req_word w);
        case (w.kind)
            KIND_RD:   model_cpu_access(1'b0, w);
            KIND_WR:   model_cpu_access(1'b1, w);
            KIND_TICK: model_dma_tick(w.budget);
            default:   ;
        endcase
    endfunction

    function automatic bit dma_running();
        return file_bytes[OFF_CTL_BYTE][0];
    endfunction

    // ------------------------------------------------------------------------
    // Result checking: every accepted result word is matched against the
    // oldest awaited one, field by field.
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            fault_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (res_bus.valid && res_bus.ready) begin
            if (awaited_results.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result word, expected none, actual kind %0d",
                         $time, res_bus.result_kind);
            end else begin
                want = awaited_results.pop_front();
                compare_field("result_kind", want.result_kind, res_bus.result_kind);
                compare_field("bus_address", want.bus_address, res_bus.bus_address);
                compare_field("copy_destination", want.copy_destination,
                              res_bus.copy_destination);
                compare_field("data", want.data, res_bus.data);
                compare_field("access_size", want.access_size, res_bus.access_size);
                compare_field("dma_irq", want.dma_irq, res_bus.dma_irq);
                compare_field("last", want.last, res_bus.last);
            end
        end
    end

    // Result side back-pressure: random stall bursts with stretches of steady
    // ready in between, none at all in the calm tail.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (no_idle || $urandom_range(0, 3) != 0) begin
                res_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0)
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end else begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                res_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    function automatic t_req_word cpu_word(input t_kind k, input logic [31:0] addr,
                                           input logic [2:0] size, input logic [31:0] data);
        t_req_word w;
        w.kind    = k;
        w.address = addr;
        w.size    = size;
        w.wdata   = data;
        w.budget  = 6'($urandom_range(0, 63));
        return w;
    endfunction

    function automatic t_req_word tick_word(input logic [5:0] budget);
        t_req_word w;
        w = cpu_word(KIND_TICK, $urandom(), 3'($urandom_range(0, 7)), $urandom());
        w.budget = budget;
        return w;
    endfunction

    // Sends one word and leaves valid high so back-to-back words flow; an idle
    // gap may come first. The model is advanced at the accepting edge, so it
    // always sees words in the order the block does.
    task automatic send_word(input t_req_word w);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.kind         <= w.kind;
        req_bus.address      <= w.address;
        req_bus.size_bytes   <= w.size;
        req_bus.write_data   <= w.wdata;
        req_bus.cycle_budget <= w.budget;
        do @(posedge i_clk); while (!req_bus.ready);
        // Ignored words and ticks of an idle engine do not count as work.
        if (w.kind != KIND_NONE && !(w.kind == KIND_TICK && !dma_running()))
            items_sent++;
        controller_step(w);
    endtask

    // Drops valid and waits until every result is in, plus a margin for
    // work that produces no result (idle ticks, DMA write-back).
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_role(input logic role);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= role;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        master_role = role;
        load_id_word();
    endtask

    function automatic logic [2:0] legal_size();
        case ($urandom_range(0, 2))
            0:       return SIZE_1;
            1:       return SIZE_2;
            default: return SIZE_4;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Register file: id word, wrap past the end, write-one-to-clear status,
    // bad sizes and the ignored kind.
    task automatic test_register_file();
        send_word(cpu_word(KIND_RD, REG_BASE | OFF_ID, SIZE_4, '0));
        send_word(cpu_word(KIND_WR, REG_BASE | 6'h3E, SIZE_4, 32'hA1B2_C3D4));
        send_word(cpu_word(KIND_RD, REG_LAST, SIZE_2, '0));
        send_word(cpu_word(KIND_WR, REG_BASE | 6'h03, SIZE_4, 32'hFFFF_FFFF));
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_STATUS, SIZE_2, 32'hFFFF_0F0F));
        send_word(cpu_word(KIND_RD, REG_BASE | OFF_STATUS, SIZE_4, '0));
        send_word(cpu_word(KIND_RD, REG_BASE | OFF_ID, 3'd0, '0));
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_ID, 3'd7, 32'hFFFF_FFFF));
        send_word(cpu_word(KIND_NONE, REG_BASE, 3'd3, 32'h1234_5678));
    endtask

    // Windows: every mapped window, the 7-bit bank mask, bank zero and
    // addresses outside any window.
    task automatic test_windows();
        send_word(cpu_word(KIND_WR, REG_BASE | 6'h18, SIZE_4, 32'h81FF_0000));
        send_word(cpu_word(KIND_WR, REG_BASE | 6'h10, SIZE_4, 32'h803C_0000));
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_BANK_18, SIZE_1, 32'h0000_0042));
        send_word(cpu_word(KIND_RD, 32'h02FF_FFFF, SIZE_4, '0));
        send_word(cpu_word(KIND_WR, 32'h0300_0000, SIZE_1, 32'hFFFF_FFFF));
        send_word(cpu_word(KIND_WR, 32'h16AB_CDEF, SIZE_2, 32'h1234_5678));
        send_word(cpu_word(KIND_RD, 32'h1712_3456, SIZE_2, '0));
        send_word(cpu_word(KIND_RD, 32'h1800_0001, SIZE_1, '0));
        send_word(cpu_word(KIND_WR, 32'hFFFF_FFFF, SIZE_4, 32'hFFFF_FFFF));
        send_word(cpu_word(KIND_RD, REG_LAST + 32'd1, SIZE_4, '0));
    endtask

    // DMA: zero budget, partial tick, clamped budget that completes with
    // the interrupt, idle tick, and a start with length zero.
    task automatic test_dma();
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_SRC, SIZE_4, 32'hFFFF_FFFC));
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_DST, SIZE_4, 32'h7FFF_FFF8));
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_CTL, SIZE_4, 32'hFF00_0005));
        send_word(tick_word(6'd0));
        send_word(tick_word(6'd2));
        send_word(tick_word(6'd63));
        send_word(tick_word(6'd32));
        send_word(cpu_word(KIND_RD, REG_BASE | OFF_CTL, SIZE_4, '0));
        send_word(cpu_word(KIND_WR, REG_BASE | OFF_CTL, SIZE_4, 32'h0100_0000));
        send_word(tick_word(6'd1));
    endtask

    // Role bit: both values, each followed by a read of the id word.
    task automatic test_role();
        set_role(1'b0);
        send_word(cpu_word(KIND_RD, REG_BASE | OFF_ID, SIZE_4, '0));
        set_role(1'b1);
        send_word(cpu_word(KIND_RD, REG_BASE | OFF_ID, SIZE_2, '0));
    endtask

    // One random episode: mostly well-formed traffic (register accesses,
    // window accesses, complete DMA programs followed by ticks), the rest
    // stray ticks and noise.
    task automatic random_episode();
        logic [5:0]  interesting [12] = '{OFF_ID, OFF_STATUS, OFF_BANK_16, OFF_BANK_17,
                                          OFF_BANK_02, OFF_BANK_03, OFF_BANK_18, OFF_SRC,
                                          OFF_DST, OFF_CTL, OFF_CTL_BYTE, 6'h3E};
        logic [7:0]  windows [6] = '{WIN_02, WIN_03, WIN_16, WIN_17, WIN_18, 8'h04};
        logic [5:0]  off;
        logic [23:0] len;
        logic [5:0]  budget;
        t_kind       rw;
        int          pick;
        pick = $urandom_range(0, 99);
        rw   = $urandom_range(0, 1) ? KIND_WR : KIND_RD;
        if (pick < 35) begin
            off = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                       : interesting[$urandom_range(0, 11)];
            send_word(cpu_word(rw, REG_BASE | off, legal_size(), $urandom()));
        end else if (pick < 55) begin
            send_word(cpu_word(rw, {windows[$urandom_range(0, 5)], 24'($urandom())},
                               legal_size(), $urandom()));
        end else if (pick < 75) begin
            case ($urandom_range(0, 5))
                0:       len = 24'd0;
                1:       len = 24'($urandom_range(41, 200));
                default: len = 24'($urandom_range(1, 40));
            endcase
            send_word(cpu_word(KIND_WR, REG_BASE | OFF_SRC, SIZE_4, $urandom()));
            send_word(cpu_word(KIND_WR, REG_BASE | OFF_DST, SIZE_4, $urandom()));
            send_word(cpu_word(KIND_WR, REG_BASE | OFF_CTL, SIZE_4,
                               {7'($urandom_range(0, 127)), 1'b1, len}));
            for (int t = 0; t < 8 && dma_running(); t++) begin
                if ($urandom_range(0, 9) == 0)
                    budget = 6'd0;
                else if ($urandom_range(0, 4) == 0)
                    budget = 6'($urandom_range(33, 63));
                else
                    budget = 6'($urandom_range(1, 32));
                send_word(tick_word(budget));
                if ($urandom_range(0, 3) == 0)
                    send_word(cpu_word(KIND_RD, REG_BASE | OFF_CTL, SIZE_4, '0));
            end
            send_word(cpu_word(KIND_RD, REG_BASE | OFF_STATUS, SIZE_2, '0));
        end else if (pick < 85) begin
            send_word(tick_word(6'($urandom_range(0, 63))));
        end else begin
            send_word(cpu_word(t_kind'($urandom_range(0, 3)), $urandom(),
                               3'($urandom_range(0, 7)), $urandom()));
        end
    endtask

    // Random run in four phases with a role change before each; the last
    // stretch runs without any idling on either side.
    task automatic test_random();
        int start;
        start = items_sent;
        for (int phase = 0; phase < 4; phase++) begin
            set_role(1'($urandom_range(0, 1)));
            while (items_sent - start < (phase + 1) * RANDOM_ITEMS / 4) begin
                if (items_sent - start >= RANDOM_ITEMS - CALM_TAIL)
                    no_idle = 1'b1;
                random_episode();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_wdata          <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.kind         <= KIND_NONE;
        req_bus.address      <= '0;
        req_bus.size_bytes   <= '0;
        req_bus.write_data   <= '0;
        req_bus.cycle_budget <= '0;
        file_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_file();
        test_windows();
        test_dma();
        test_role();
        test_random();

        wait_idle();
        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
